// ----- rtl/terminal_cursor_scroll_controller_core_defines.svh -----
// Assertion macros shared by the cursor and scroll controller RTL.
`ifndef TERMINAL_CURSOR_SCROLL_CONTROLLER_CORE_DEFINES_SVH
`define TERMINAL_CURSOR_SCROLL_CONTROLLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define TCSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle that implies a consequence in the next cycle.
`define TCSC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TCSC_ASSERT(label, clk, rst, prop, msg)
`define TCSC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/tcsc_pkg.sv -----
// Types, constants and the character width lookup of the cursor and scroll controller.
package tcsc_pkg;

   localparam int OPCODE_W    = 5;
   localparam int CODE_W      = 21;
   localparam int ARG_W       = 16;
   localparam int KIND_W      = 3;
   localparam int OUT_ROW_W   = 7;
   localparam int OUT_COL_W   = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int ROWS_CFG_W  = 8;
   localparam int COLS_CFG_W  = 9;

   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 256;
   localparam int RESET_ROWS   = 24;
   localparam int RESET_COLS   = 80;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSERT_MODE = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PRINT       = 5'd0,
      OP_NEWLINE     = 5'd1,
      OP_BACKSPACE   = 5'd2,
      OP_CR          = 5'd3,
      OP_REV_INDEX   = 5'd4,
      OP_LEFT        = 5'd5,
      OP_RIGHT       = 5'd6,
      OP_UP          = 5'd7,
      OP_DOWN        = 5'd8,
      OP_SET_COL     = 5'd9,
      OP_SET_ROW     = 5'd10,
      OP_SET_POS     = 5'd11,
      OP_LINE_START  = 5'd12,
      OP_LINE_END    = 5'd13,
      OP_SET_REGION  = 5'd14,
      OP_SAVE        = 5'd15,
      OP_RESTORE     = 5'd16,
      OP_RESET       = 5'd17
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPORT      = 3'd0,
      KIND_WRITE       = 3'd1,
      KIND_INSERT      = 3'd2,
      KIND_SCROLL_UP   = 3'd3,
      KIND_SCROLL_DOWN = 3'd4
   } kind_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CODE_W-1:0]   code_point;
      logic [ARG_W-1:0]    arg_a;
      logic [ARG_W-1:0]    arg_b;
   } cmd_type;

   typedef struct packed {
      kind_type             kind;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [CODE_W-1:0]    code;
      logic                 filler;
   } item_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] region_top;
      logic [OUT_ROW_W-1:0] region_bottom;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_COL_W-1:0] cursor_col;
      logic                 wrap_pending;
   } status_type;

   typedef struct packed {
      logic                   write_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_wr_type;

   localparam int NUM_ZERO = 8;
   localparam int NUM_WIDE = 21;

   localparam logic [CODE_W-1:0] ZERO_LO [NUM_ZERO] = '{
      21'h0300, 21'h0483, 21'h0591, 21'h0610, 21'h064B, 21'h1DC0, 21'h20D0, 21'hFE20};
   localparam logic [CODE_W-1:0] ZERO_HI [NUM_ZERO] = '{
      21'h036F, 21'h0489, 21'h05BD, 21'h061A, 21'h065F, 21'h1DFF, 21'h20FF, 21'hFE2F};

   localparam logic [CODE_W-1:0] WIDE_LO [NUM_WIDE] = '{
      21'h1100, 21'h2E80, 21'h3041, 21'h3400, 21'h4E00, 21'hA000, 21'hA960,
      21'hAC00, 21'hF900, 21'hFE10, 21'hFE30, 21'hFF01, 21'hFFE0, 21'h1B000,
      21'h1F004, 21'h1F0CF, 21'h1F200, 21'h1F300, 21'h1F900, 21'h20000, 21'h30000};
   localparam logic [CODE_W-1:0] WIDE_HI [NUM_WIDE] = '{
      21'h115F, 21'h303E, 21'h33FF, 21'h4DBF, 21'h9FFF, 21'hA4CF, 21'hA97F,
      21'hD7A3, 21'hFAFF, 21'hFE19, 21'hFE6F, 21'hFF60, 21'hFFE6, 21'h1B2FF,
      21'h1F004, 21'h1F0CF, 21'h1F2FF, 21'h1F64F, 21'h1F9FF, 21'h2FFFD, 21'h3FFFD};

   // Display width in cells: 0 for NUL and combining marks, 2 for wide ranges, else 1.
   function automatic logic [1:0] char_width(input logic [CODE_W-1:0] cp);
      logic zero_hit;
      logic wide_hit;
      zero_hit = (cp == '0);
      wide_hit = 1'b0;
      for (int i = 0; i < NUM_ZERO; i++) begin
         if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) zero_hit = 1'b1;
      end
      for (int i = 0; i < NUM_WIDE; i++) begin
         if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) wide_hit = 1'b1;
      end
      if (zero_hit) return 2'd0;
      if (wide_hit) return 2'd2;
      return 2'd1;
   endfunction

endpackage

// ----- rtl/tcsc_step.sv -----
// Cursor, wrap, region and saved-cursor state with the per-command update logic.
`include "terminal_cursor_scroll_controller_core_defines.svh"
module tcsc_step #(
   parameter int MAX_ROWS = tcsc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tcsc_pkg::DEF_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tcsc_pkg::csr_wr_type             csr,
   input  logic                             fire,
   input  tcsc_pkg::cmd_type                cmd,
   output tcsc_pkg::item_type [2:0]         items,
   output logic [1:0]                       item_count,
   output tcsc_pkg::status_type             status
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = tcsc_pkg::ARG_W;
   localparam int RESET_ROWS_EFF =
      (tcsc_pkg::RESET_ROWS < MAX_ROWS) ? tcsc_pkg::RESET_ROWS : MAX_ROWS;
   localparam int RESET_COLS_EFF =
      (tcsc_pkg::RESET_COLS < MAX_COLS) ? tcsc_pkg::RESET_COLS : MAX_COLS;
   localparam logic [RW-1:0] RESET_LAST_ROW = RW'(RESET_ROWS_EFF - 1);
   localparam logic [CW-1:0] RESET_LAST_COL = CW'(RESET_COLS_EFF - 1);

   logic [RW-1:0] row_ff, row_in, top_ff, top_in, bot_ff, bot_in;
   logic [RW-1:0] saved_row_ff, saved_row_in, last_row_ff, last_row_in;
   logic [CW-1:0] col_ff, col_in, saved_col_ff, saved_col_in, last_col_ff, last_col_in;
   logic          wrap_ff, wrap_in, insert_ff, insert_in;

   // Configuration decode.
   logic [tcsc_pkg::ROWS_CFG_W-1:0] cfg_rows;
   logic [tcsc_pkg::COLS_CFG_W-1:0] cfg_cols;
   logic [RW-1:0]                   cfg_last_row;
   logic [CW-1:0]                   cfg_last_col;

   // Shared pieces of the command logic.
   tcsc_pkg::opcode_type op;
   logic [AW-1:0] cnt, a_m1, b_m1;
   logic [AW:0]   row_sum, col_sum;
   logic [RW-1:0] row_pos_a, nl_row, p_row, reg_top, reg_bot;
   logic [CW-1:0] col_pos_a, col_pos_b, p_col;
   logic          nl_scroll, p_scroll, has_filler;
   logic [1:0]    cw;
   logic [CW:0]   ncol;
   tcsc_pkg::kind_type cell_kind;
   tcsc_pkg::item_type cell_item, filler_item, report_item, up_item, down_item;

   assign cfg_rows = csr.data[tcsc_pkg::ROWS_CFG_W-1:0];
   assign cfg_cols = csr.data[tcsc_pkg::COLS_CFG_W-1:0];

   always_comb begin
      if (cfg_rows == '0) begin
         cfg_last_row = '0;
      end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
         cfg_last_row = RW'(MAX_ROWS - 1);
      end else begin
         cfg_last_row = RW'(32'(cfg_rows) - 32'd1);
      end
      if (cfg_cols == '0) begin
         cfg_last_col = '0;
      end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
         cfg_last_col = CW'(MAX_COLS - 1);
      end else begin
         cfg_last_col = CW'(32'(cfg_cols) - 32'd1);
      end
   end

   assign op   = tcsc_pkg::opcode_type'(cmd.opcode);
   assign cnt  = (cmd.arg_a == '0) ? AW'(1) : cmd.arg_a;
   assign a_m1 = (cmd.arg_a == '0) ? '0 : cmd.arg_a - AW'(1);
   assign b_m1 = (cmd.arg_b == '0) ? '0 : cmd.arg_b - AW'(1);
   assign row_sum = (AW+1)'(row_ff) + (AW+1)'(cnt);
   assign col_sum = (AW+1)'(col_ff) + (AW+1)'(cnt);

   assign row_pos_a = (a_m1 > AW'(last_row_ff)) ? last_row_ff : RW'(a_m1);
   assign col_pos_a = (a_m1 > AW'(last_col_ff)) ? last_col_ff : CW'(a_m1);
   assign col_pos_b = (b_m1 > AW'(last_col_ff)) ? last_col_ff : CW'(b_m1);

   // Region arguments: top past the grid falls back to row 0, a bad bottom to the last row.
   always_comb begin
      reg_top = (a_m1 > AW'(last_row_ff)) ? '0 : RW'(a_m1);
      if (cmd.arg_b == '0 || b_m1 > AW'(last_row_ff)) begin
         reg_bot = last_row_ff;
      end else begin
         reg_bot = RW'(b_m1);
      end
      if (reg_bot < reg_top) reg_bot = last_row_ff;
   end

   // Line feed: scroll at the region bottom, saturate below the region.
   always_comb begin
      nl_scroll = 1'b0;
      nl_row    = row_ff;
      if (row_ff < bot_ff) begin
         nl_row = row_ff + RW'(1);
      end else if (row_ff == bot_ff) begin
         nl_scroll = 1'b1;
      end else if (row_ff < last_row_ff) begin
         nl_row = row_ff + RW'(1);
      end
   end

   // Printing starts from the wrapped position when a wrap is pending.
   assign p_row      = wrap_ff ? nl_row : row_ff;
   assign p_col      = wrap_ff ? '0 : col_ff;
   assign p_scroll   = wrap_ff && nl_scroll;
   assign cw         = tcsc_pkg::char_width(cmd.code_point);
   assign has_filler = (cw == 2'd2) && (p_col < last_col_ff);
   assign ncol       = (CW+1)'(p_col) + (CW+1)'(cw);
   assign cell_kind  = insert_ff ? tcsc_pkg::KIND_INSERT : tcsc_pkg::KIND_WRITE;

   always_comb begin
      report_item        = '0;
      report_item.kind   = tcsc_pkg::KIND_REPORT;
      up_item            = '0;
      up_item.kind       = tcsc_pkg::KIND_SCROLL_UP;
      down_item          = '0;
      down_item.kind     = tcsc_pkg::KIND_SCROLL_DOWN;
      cell_item.kind     = cell_kind;
      cell_item.row      = tcsc_pkg::OUT_ROW_W'(p_row);
      cell_item.col      = tcsc_pkg::OUT_COL_W'(p_col);
      cell_item.code     = cmd.code_point;
      cell_item.filler   = 1'b0;
      filler_item.kind   = cell_kind;
      filler_item.row    = tcsc_pkg::OUT_ROW_W'(p_row);
      filler_item.col    = tcsc_pkg::OUT_COL_W'(p_col + CW'(1));
      filler_item.code   = '0;
      filler_item.filler = 1'b1;
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      wrap_in      = wrap_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      saved_row_in = saved_row_ff;
      saved_col_in = saved_col_ff;
      last_row_in  = last_row_ff;
      last_col_in  = last_col_ff;
      insert_in    = insert_ff;
      items        = {report_item, report_item, report_item};
      item_count   = 2'd1;

      if (csr.write_en) begin
         if (csr.index == tcsc_pkg::CSR_GRID_ROWS || csr.index == tcsc_pkg::CSR_GRID_COLS) begin
            if (csr.index == tcsc_pkg::CSR_GRID_ROWS) begin
               last_row_in = cfg_last_row;
            end else begin
               last_col_in = cfg_last_col;
            end
            // A resize resets the region and pulls the cursor back onto the grid.
            top_in  = '0;
            bot_in  = last_row_in;
            wrap_in = 1'b0;
            row_in  = (row_ff > last_row_in) ? last_row_in : row_ff;
            col_in  = (col_ff > last_col_in) ? last_col_in : col_ff;
         end else if (csr.index == tcsc_pkg::CSR_INSERT_MODE) begin
            insert_in = csr.data[0];
         end
      end else if (fire) begin
         unique case (op)
            tcsc_pkg::OP_PRINT: begin
               row_in = p_row;
               if (ncol > (CW+1)'(last_col_ff)) begin
                  col_in  = p_col;
                  wrap_in = 1'b1;
               end else begin
                  col_in  = CW'(ncol);
                  wrap_in = 1'b0;
               end
               if (p_scroll) begin
                  items      = {filler_item, cell_item, up_item};
                  item_count = has_filler ? 2'd3 : 2'd2;
               end else begin
                  items      = {report_item, filler_item, cell_item};
                  item_count = has_filler ? 2'd2 : 2'd1;
               end
            end
            tcsc_pkg::OP_NEWLINE: begin
               wrap_in = 1'b0;
               row_in  = nl_row;
               col_in  = '0;
               if (nl_scroll) items[0] = up_item;
            end
            tcsc_pkg::OP_BACKSPACE: begin
               wrap_in = 1'b0;
               if (col_ff != '0) col_in = col_ff - CW'(1);
            end
            tcsc_pkg::OP_CR, tcsc_pkg::OP_LINE_START: begin
               wrap_in = 1'b0;
               col_in  = '0;
            end
            tcsc_pkg::OP_REV_INDEX: begin
               if (row_ff == top_ff) begin
                  items[0] = down_item;
               end else if (row_ff != '0) begin
                  row_in = row_ff - RW'(1);
               end
            end
            tcsc_pkg::OP_LEFT: begin
               wrap_in = 1'b0;
               col_in  = (AW'(col_ff) >= cnt) ? CW'(AW'(col_ff) - cnt) : '0;
            end
            tcsc_pkg::OP_RIGHT: begin
               wrap_in = 1'b0;
               col_in  = (col_sum > (AW+1)'(last_col_ff)) ? last_col_ff : CW'(col_sum);
            end
            tcsc_pkg::OP_UP: begin
               wrap_in = 1'b0;
               row_in  = (AW'(row_ff) >= cnt) ? RW'(AW'(row_ff) - cnt) : '0;
            end
            tcsc_pkg::OP_DOWN: begin
               wrap_in = 1'b0;
               row_in  = (row_sum > (AW+1)'(last_row_ff)) ? last_row_ff : RW'(row_sum);
            end
            tcsc_pkg::OP_SET_COL: begin
               wrap_in = 1'b0;
               col_in  = col_pos_a;
            end
            tcsc_pkg::OP_SET_ROW: begin
               wrap_in = 1'b0;
               row_in  = row_pos_a;
            end
            tcsc_pkg::OP_SET_POS: begin
               wrap_in = 1'b0;
               row_in  = row_pos_a;
               col_in  = col_pos_b;
            end
            tcsc_pkg::OP_LINE_END: begin
               wrap_in = 1'b0;
               col_in  = last_col_ff;
            end
            tcsc_pkg::OP_SET_REGION: begin
               top_in  = reg_top;
               bot_in  = reg_bot;
               wrap_in = 1'b0;
               row_in  = reg_top;
               col_in  = '0;
            end
            tcsc_pkg::OP_SAVE: begin
               saved_row_in = row_ff;
               saved_col_in = col_ff;
            end
            tcsc_pkg::OP_RESTORE: begin
               wrap_in = 1'b0;
               row_in  = (saved_row_ff > last_row_ff) ? last_row_ff : saved_row_ff;
               col_in  = (saved_col_ff > last_col_ff) ? last_col_ff : saved_col_ff;
            end
            tcsc_pkg::OP_RESET: begin
               top_in       = '0;
               bot_in       = last_row_ff;
               saved_row_in = '0;
               saved_col_in = '0;
               insert_in    = 1'b0;
               wrap_in      = 1'b0;
               row_in       = '0;
               col_in       = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         wrap_ff      <= 1'b0;
         top_ff       <= '0;
         bot_ff       <= RESET_LAST_ROW;
         saved_row_ff <= '0;
         saved_col_ff <= '0;
         last_row_ff  <= RESET_LAST_ROW;
         last_col_ff  <= RESET_LAST_COL;
         insert_ff    <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         wrap_ff      <= wrap_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         saved_row_ff <= saved_row_in;
         saved_col_ff <= saved_col_in;
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         insert_ff    <= insert_in;
      end
   end

   assign status.region_top    = tcsc_pkg::OUT_ROW_W'(top_ff);
   assign status.region_bottom = tcsc_pkg::OUT_ROW_W'(bot_ff);
   assign status.cursor_row    = tcsc_pkg::OUT_ROW_W'(row_ff);
   assign status.cursor_col    = tcsc_pkg::OUT_COL_W'(col_ff);
   assign status.wrap_pending  = wrap_ff;

   `TCSC_ASSERT(a_cursor_on_grid, clock, reset,
      (row_ff <= last_row_ff) && (col_ff <= last_col_ff), "cursor left the grid")
   `TCSC_ASSERT(a_region_ordered, clock, reset,
      (top_ff <= bot_ff) && (bot_ff <= last_row_ff), "scroll region out of order")

endmodule

// ----- rtl/tcsc_rsp_buf.sv -----
// Result buffer that holds up to three result items of one command and sends them in order.
`include "terminal_cursor_scroll_controller_core_defines.svh"
module tcsc_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tcsc_pkg::item_type [2:0] items_in,
   input  logic [1:0]               count_in,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output tcsc_pkg::item_type       item_out,
   output logic                     last,
   output logic                     free
);

   tcsc_pkg::item_type [2:0] items_ff, items_in_next;
   logic [1:0] count_ff, count_in_next, idx_ff, idx_in;
   logic       xfer;

   assign rsp_valid = (count_ff != 2'd0);
   assign last      = (idx_ff == count_ff - 2'd1);
   assign xfer      = rsp_valid && !rsp_stall;
   // Free for the next command once empty or while its final item transfers.
   assign free      = !rsp_valid || (last && !rsp_stall);

   always_comb begin
      unique case (idx_ff)
         2'd0:    item_out = items_ff[0];
         2'd1:    item_out = items_ff[1];
         default: item_out = items_ff[2];
      endcase
   end

   always_comb begin
      items_in_next = items_ff;
      count_in_next = count_ff;
      idx_in        = idx_ff;
      if (load) begin
         items_in_next = items_in;
         count_in_next = count_in;
         idx_in        = 2'd0;
      end else if (xfer) begin
         if (last) begin
            count_in_next = 2'd0;
            idx_in        = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in_next;
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in_next;
         idx_ff   <= idx_in;
      end
   end

   `TCSC_ASSERT(a_idx_in_range, clock, reset,
      (count_ff == 2'd0) || (idx_ff < count_ff), "result index past item count")
   `TCSC_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid && rsp_stall && !load,
      $stable(idx_ff) && $stable(count_ff), "result buffer moved while stalled")

endmodule

// ----- rtl/terminal_cursor_scroll_controller_core.sv -----
// Top level of the terminal cursor, wrap and scroll-region controller.
//
// The request channel (req_*) takes one decoded terminal command per transfer:
// an opcode, a code point for printing and two 1-indexed arguments. The result
// channel (rsp_*) returns one to three result items per command: cell writes or
// inserts, scroll commands for an external cell store, or a single cursor report
// when the command produces nothing else. Every item carries the scroll region,
// cursor and pending-wrap flag as they stand after the command; rsp_last marks
// the final item of a command. Both channels use valid and stall.
// A command is held in an input register, evaluated by combinational logic and
// written into a three-entry result buffer, which sends the one to three result
// items of each command in order. A new command is evaluated in the cycle its
// predecessor's last item transfers. When the receiver stalls, the buffer holds
// its item and the input register holds one more command, after which req_stall
// rises. Reset is synchronous and active high; it empties both stages, sets the
// grid to 24 by 80, clears insert mode and homes the cursor. The csr_* port
// writes grid size and insert mode; the user must write it only while idle, as
// the block itself does not enforce this.
`include "terminal_cursor_scroll_controller_core_defines.svh"
module terminal_cursor_scroll_controller_core #(
   parameter int MAX_ROWS = tcsc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tcsc_pkg::DEF_MAX_COLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tcsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcsc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tcsc_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [tcsc_pkg::CODE_W-1:0]       req_code_point,
   input  logic [tcsc_pkg::ARG_W-1:0]        req_arg_a,
   input  logic [tcsc_pkg::ARG_W-1:0]        req_arg_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcsc_pkg::KIND_W-1:0]       rsp_kind,
   output logic [tcsc_pkg::OUT_ROW_W-1:0]    rsp_cell_row,
   output logic [tcsc_pkg::OUT_COL_W-1:0]    rsp_cell_col,
   output logic [tcsc_pkg::CODE_W-1:0]      rsp_cell_code,
   output logic                              rsp_is_filler,
   output logic [tcsc_pkg::OUT_ROW_W-1:0]    rsp_region_top,
   output logic [tcsc_pkg::OUT_ROW_W-1:0]    rsp_region_bottom,
   output logic [tcsc_pkg::OUT_ROW_W-1:0]    rsp_cursor_row_out,
   output logic [tcsc_pkg::OUT_COL_W-1:0]    rsp_cursor_col_out,
   output logic                              rsp_wrap_pending_out,
   output logic                              rsp_last
);

   tcsc_pkg::cmd_type        cmd_ff, cmd_in;
   logic                     in_valid_ff, in_valid_in;
   logic                     fire, buf_free;
   tcsc_pkg::csr_wr_type     csr;
   tcsc_pkg::item_type [2:0] step_items;
   logic [1:0]               step_count;
   tcsc_pkg::item_type       item_out;
   tcsc_pkg::status_type     status;

   // The held command is evaluated as soon as the result buffer can take its items.
   assign fire      = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      cmd_in      = cmd_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_valid && !req_stall) begin
         cmd_in.opcode     = req_opcode;
         cmd_in.code_point = req_code_point;
         cmd_in.arg_a      = req_arg_a;
         cmd_in.arg_b      = req_arg_b;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.data     = csr_data;

   tcsc_step #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .fire       (fire),
      .cmd        (cmd_ff),
      .items      (step_items),
      .item_count (step_count),
      .status     (status)
   );

   tcsc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .items_in  (step_items),
      .count_in  (step_count),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .item_out  (item_out),
      .last      (rsp_last),
      .free      (buf_free)
   );

   // State registers change only on a csr_* write or when a command is evaluated, which
   // is also when its items enter the buffer, so every item reports the post-command state.
   assign rsp_kind             = item_out.kind;
   assign rsp_cell_row         = item_out.row;
   assign rsp_cell_col         = item_out.col;
   assign rsp_cell_code        = item_out.code;
   assign rsp_is_filler        = item_out.filler;
   assign rsp_region_top       = status.region_top;
   assign rsp_region_bottom    = status.region_bottom;
   assign rsp_cursor_row_out   = status.cursor_row;
   assign rsp_cursor_col_out   = status.cursor_col;
   assign rsp_wrap_pending_out = status.wrap_pending;

   `TCSC_ASSERT_NEXT(a_stalled_cmd_held, clock, reset, req_stall,
      in_valid_ff && $stable(cmd_ff), "held command lost or changed while stalled")

endmodule

// ----- sim/terminal_cursor_scroll_controller_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the terminal cursor, wrap and scroll-region controller.
module terminal_cursor_scroll_controller_core_test;
   import tcsc_pkg::*;

   // Index 3 of the register port decodes to nothing; writing it must be harmless.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   // Highest opcode the field can carry; everything above OP_RESET is ignored.
   localparam logic [OPCODE_W-1:0] OP_UNUSED_TOP = 5'd31;

   localparam int IDLE_LIMIT  = 5000;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 50;

   // Grid settings per phase; the last phase draws a small random grid instead.
   localparam logic [CSR_DATA_W-1:0] PHASE_ROWS [NUM_PHASES] = '{
      9'd1, 9'd128, 9'h100, 9'h1FF, 9'd5, 9'd3, 9'd24, 9'd0};
   localparam logic [CSR_DATA_W-1:0] PHASE_COLS [NUM_PHASES] = '{
      9'd1, 9'd256, 9'd0, 9'h1FF, 9'd7, 9'd2, 9'd80, 9'd0};
   localparam bit PHASE_INSERT [NUM_PHASES] = '{1, 0, 0, 1, 0, 1, 0, 0};

   // Code points on either side of the width table boundaries.
   localparam int NUM_BOUNDARY = 24;
   localparam logic [CODE_W-1:0] BOUNDARY_POINTS [NUM_BOUNDARY] = '{
      21'h0000, 21'h02FF, 21'h0300, 21'h036F, 21'h0370, 21'h10FF, 21'h1100, 21'h115F,
      21'h1160, 21'h4DC0, 21'h4E00, 21'h9FFF, 21'hABFF, 21'hAC00, 21'hD7A3, 21'hD7A4,
      21'h1FFFF, 21'h20000, 21'h2FFFD, 21'h2FFFE, 21'h3FFFD, 21'h3FFFE, 21'hFE2F,
      21'h10FFFF};

   // One command for the external cell store, with the status stamped on it.
   typedef struct packed {
      kind_type             kind;
      logic [OUT_ROW_W-1:0] cell_row;
      logic [OUT_COL_W-1:0] cell_col;
      logic [CODE_W-1:0]    cell_code;
      logic                 is_filler;
      logic [OUT_ROW_W-1:0] region_top;
      logic [OUT_ROW_W-1:0] region_bottom;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_COL_W-1:0] cursor_col;
      logic                 wrap_pending;
      logic                 last;
   } grid_op_type;

   // Tracks cursor, wrap flag, region and saved cursor, and holds the grid
   // commands still owed by the block in order.
   class cursor_tracker;
      int unsigned          rows;
      int unsigned          cols;
      bit                   insert_on;
      logic [OUT_ROW_W-1:0] cur_row;
      logic [OUT_COL_W-1:0] cur_col;
      bit                   wrap;
      logic [OUT_ROW_W-1:0] top_row;
      logic [OUT_ROW_W-1:0] bottom_row;
      logic [OUT_ROW_W-1:0] saved_row;
      logic [OUT_COL_W-1:0] saved_col;
      grid_op_type          ops_due[$];
      grid_op_type          step_ops[$];
      int                   errors;

      function new();
         rows       = RESET_ROWS;
         cols       = RESET_COLS;
         insert_on  = 1'b0;
         cur_row    = '0;
         cur_col    = '0;
         wrap       = 1'b0;
         top_row    = '0;
         bottom_row = OUT_ROW_W'(rows - 1);
         saved_row  = '0;
         saved_col  = '0;
         errors     = 0;
      endfunction

      function int unsigned lesser(int unsigned x, int unsigned y);
         return (x < y) ? x : y;
      endfunction

      // 1-indexed argument to a 0-indexed position; 0 means the first one.
      function int unsigned place(int unsigned arg, int unsigned lim);
         return lesser((arg == 0) ? 0 : arg - 1, lim - 1);
      endfunction

      function int unsigned cell_span(logic [CODE_W-1:0] cp);
         if (cp == '0 || cp inside {[21'h0300:21'h036F], [21'h0483:21'h0489],
               [21'h0591:21'h05BD], [21'h0610:21'h061A], [21'h064B:21'h065F],
               [21'h1DC0:21'h1DFF], [21'h20D0:21'h20FF], [21'hFE20:21'hFE2F]})
            return 0;
         if (cp inside {[21'h1100:21'h115F], [21'h2E80:21'h303E], [21'h3041:21'h33FF],
               [21'h3400:21'h4DBF], [21'h4E00:21'h9FFF], [21'hA000:21'hA4CF],
               [21'hA960:21'hA97F], [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF],
               [21'hFE10:21'hFE19], [21'hFE30:21'hFE6F], [21'hFF01:21'hFF60],
               [21'hFFE0:21'hFFE6], [21'h1B000:21'h1B2FF], 21'h1F004, 21'h1F0CF,
               [21'h1F200:21'h1F2FF], [21'h1F300:21'h1F64F], [21'h1F900:21'h1F9FF],
               [21'h20000:21'h2FFFD], [21'h30000:21'h3FFFD]})
            return 2;
         return 1;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] data);
         int unsigned v;
         if (idx == CSR_GRID_ROWS || idx == CSR_GRID_COLS) begin
            if (idx == CSR_GRID_ROWS) begin
               v    = data[ROWS_CFG_W-1:0];
               rows = (v < 1) ? 1 : (v > DEF_MAX_ROWS) ? DEF_MAX_ROWS : v;
            end else begin
               v    = data[COLS_CFG_W-1:0];
               cols = (v < 1) ? 1 : (v > DEF_MAX_COLS) ? DEF_MAX_COLS : v;
            end
            // A resize restores the full region and pulls the cursor onto the grid.
            top_row    = '0;
            bottom_row = OUT_ROW_W'(rows - 1);
            wrap       = 1'b0;
            cur_row    = OUT_ROW_W'(lesser(cur_row, rows - 1));
            cur_col    = OUT_COL_W'(lesser(cur_col, cols - 1));
         end else if (idx == CSR_INSERT_MODE) begin
            insert_on = data[0];
         end
      endfunction

      function void emit(kind_type k, int unsigned r, int unsigned c,
                         logic [CODE_W-1:0] code, bit filler);
         grid_op_type entry;
         entry           = '0;
         entry.kind      = k;
         entry.cell_row  = OUT_ROW_W'(r);
         entry.cell_col  = OUT_COL_W'(c);
         entry.cell_code = code;
         entry.is_filler = filler;
         step_ops.insert(step_ops.size(), entry);
      endfunction

      function void line_feed();
         wrap = 1'b0;
         if (cur_row < bottom_row) begin
            cur_row = cur_row + 1'b1;
         end else if (cur_row == bottom_row) begin
            emit(KIND_SCROLL_UP, 0, 0, '0, 1'b0);
         end else begin
            cur_row = OUT_ROW_W'(lesser(int'(cur_row) + 1, rows - 1));
         end
         cur_col = '0;
      endfunction

      // Works out the grid commands caused by one accepted command.
      function void take_command(logic [OPCODE_W-1:0] opcode, logic [CODE_W-1:0] cp,
                                 logic [ARG_W-1:0] a, logic [ARG_W-1:0] b);
         int unsigned n;
         int unsigned w;
         int unsigned t;
         int unsigned bt;
         kind_type    k;
         step_ops.delete();
         n = (a == 0) ? 1 : a;
         case (opcode)
            OP_PRINT: begin
               if (wrap) line_feed();
               w = cell_span(cp);
               k = insert_on ? KIND_INSERT : KIND_WRITE;
               emit(k, cur_row, cur_col, cp, 1'b0);
               // The right half of a wide character only lands if it is on the grid.
               if (w == 2 && int'(cur_col) + 1 < cols)
                  emit(k, cur_row, int'(cur_col) + 1, '0, 1'b1);
               if (int'(cur_col) + w >= cols) wrap = 1'b1;
               else cur_col = OUT_COL_W'(int'(cur_col) + w);
            end
            OP_NEWLINE: line_feed();
            OP_BACKSPACE: begin
               wrap = 1'b0;
               if (cur_col > 0) cur_col = cur_col - 1'b1;
            end
            OP_CR, OP_LINE_START: begin
               wrap    = 1'b0;
               cur_col = '0;
            end
            OP_REV_INDEX: begin
               if (cur_row == top_row) emit(KIND_SCROLL_DOWN, 0, 0, '0, 1'b0);
               else if (cur_row > 0) cur_row = cur_row - 1'b1;
            end
            OP_LEFT: begin
               wrap    = 1'b0;
               cur_col = (cur_col >= n) ? OUT_COL_W'(cur_col - n) : '0;
            end
            OP_RIGHT: begin
               wrap    = 1'b0;
               cur_col = OUT_COL_W'(lesser(cur_col + n, cols - 1));
            end
            OP_UP: begin
               wrap    = 1'b0;
               cur_row = (cur_row >= n) ? OUT_ROW_W'(cur_row - n) : '0;
            end
            OP_DOWN: begin
               wrap    = 1'b0;
               cur_row = OUT_ROW_W'(lesser(cur_row + n, rows - 1));
            end
            OP_SET_COL: begin
               wrap    = 1'b0;
               cur_col = OUT_COL_W'(place(a, cols));
            end
            OP_SET_ROW: begin
               wrap    = 1'b0;
               cur_row = OUT_ROW_W'(place(a, rows));
            end
            OP_SET_POS: begin
               wrap    = 1'b0;
               cur_row = OUT_ROW_W'(place(a, rows));
               cur_col = OUT_COL_W'(place(b, cols));
            end
            OP_LINE_END: begin
               wrap    = 1'b0;
               cur_col = OUT_COL_W'(cols - 1);
            end
            OP_SET_REGION: begin
               t  = (a == 0) ? 0 : a - 1;
               bt = (b == 0 || b > rows) ? rows - 1 : b - 1;
               if (t >= rows) t = 0;
               if (bt < t) bt = rows - 1;
               top_row    = OUT_ROW_W'(t);
               bottom_row = OUT_ROW_W'(bt);
               wrap       = 1'b0;
               cur_row    = OUT_ROW_W'(t);
               cur_col    = '0;
            end
            OP_SAVE: begin
               saved_row = cur_row;
               saved_col = cur_col;
            end
            OP_RESTORE: begin
               wrap    = 1'b0;
               cur_row = OUT_ROW_W'(lesser(saved_row, rows - 1));
               cur_col = OUT_COL_W'(lesser(saved_col, cols - 1));
            end
            OP_RESET: begin
               top_row    = '0;
               bottom_row = OUT_ROW_W'(rows - 1);
               saved_row  = '0;
               saved_col  = '0;
               insert_on  = 1'b0;
               wrap       = 1'b0;
               cur_row    = '0;
               cur_col    = '0;
            end
            default: ;
         endcase
         // A command with no cell or scroll work still answers with a cursor report.
         if (step_ops.size() == 0) emit(KIND_REPORT, 0, 0, '0, 1'b0);
         foreach (step_ops[i]) begin
            step_ops[i].region_top    = top_row;
            step_ops[i].region_bottom = bottom_row;
            step_ops[i].cursor_row    = cur_row;
            step_ops[i].cursor_col    = cur_col;
            step_ops[i].wrap_pending  = wrap;
            step_ops[i].last          = (i == step_ops.size() - 1);
            ops_due.insert(ops_due.size(), step_ops[i]);
         end
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void match_output(grid_op_type got);
         grid_op_type want;
         if (ops_due.size() == 0) begin
            $error("result transfer with nothing outstanding: kind %0d", got.kind);
            errors++;
            return;
         end
         want = ops_due[0];
         ops_due.delete(0);
         compare("kind", want.kind, got.kind);
         compare("cell_row", want.cell_row, got.cell_row);
         compare("cell_col", want.cell_col, got.cell_col);
         compare("cell_code", want.cell_code, got.cell_code);
         compare("is_filler", want.is_filler, got.is_filler);
         compare("region_top", want.region_top, got.region_top);
         compare("region_bottom", want.region_bottom, got.region_bottom);
         compare("cursor_row_out", want.cursor_row, got.cursor_row);
         compare("cursor_col_out", want.cursor_col, got.cursor_col);
         compare("wrap_pending_out", want.wrap_pending, got.wrap_pending);
         compare("last", want.last, got.last);
      endfunction
   endclass

   bit                     clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [CODE_W-1:0]      req_code_point;
   logic [ARG_W-1:0]       req_arg_a;
   logic [ARG_W-1:0]       req_arg_b;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KIND_W-1:0]      rsp_kind;
   logic [OUT_ROW_W-1:0]   rsp_cell_row;
   logic [OUT_COL_W-1:0]   rsp_cell_col;
   logic [CODE_W-1:0]      rsp_cell_code;
   logic                   rsp_is_filler;
   logic [OUT_ROW_W-1:0]   rsp_region_top;
   logic [OUT_ROW_W-1:0]   rsp_region_bottom;
   logic [OUT_ROW_W-1:0]   rsp_cursor_row_out;
   logic [OUT_COL_W-1:0]   rsp_cursor_col_out;
   logic                   rsp_wrap_pending_out;
   logic                   rsp_last;

   // Set for one phase so that both sides run without any gaps.
   bit                     quiet;
   cursor_tracker          tracker;

   terminal_cursor_scroll_controller_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_code_point       (req_code_point),
      .req_arg_a            (req_arg_a),
      .req_arg_b            (req_arg_b),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_cell_row         (rsp_cell_row),
      .rsp_cell_col         (rsp_cell_col),
      .rsp_cell_code        (rsp_cell_code),
      .rsp_is_filler        (rsp_is_filler),
      .rsp_region_top       (rsp_region_top),
      .rsp_region_bottom    (rsp_region_bottom),
      .rsp_cursor_row_out   (rsp_cursor_row_out),
      .rsp_cursor_col_out   (rsp_cursor_col_out),
      .rsp_wrap_pending_out (rsp_wrap_pending_out),
      .rsp_last             (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Receiver: stalls about one cycle in six, except during the quiet phase.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !quiet && ($urandom_range(99) < 16);
      end
   end

   // Every result transfer is checked against the oldest owed grid command.
   always @(posedge clock) begin
      grid_op_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind          = kind_type'(rsp_kind);
         got.cell_row      = rsp_cell_row;
         got.cell_col      = rsp_cell_col;
         got.cell_code     = rsp_cell_code;
         got.is_filler     = rsp_is_filler;
         got.region_top    = rsp_region_top;
         got.region_bottom = rsp_region_bottom;
         got.cursor_row    = rsp_cursor_row_out;
         got.cursor_col    = rsp_cursor_col_out;
         got.wrap_pending  = rsp_wrap_pending_out;
         got.last          = rsp_last;
         tracker.match_output(got);
      end
   end

   // Ends the run if neither channel completes a transfer for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one command, with random idle cycles ahead of it, and holds it until
   // the transfer completes. The valid stays high for a back-to-back follower.
   task automatic send_command(input logic [OPCODE_W-1:0] opcode,
                               input logic [CODE_W-1:0] cp,
                               input logic [ARG_W-1:0] a, input logic [ARG_W-1:0] b);
      while (!quiet && $urandom_range(99) < 16) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= opcode;
      req_code_point <= cp;
      req_arg_a      <= a;
      req_arg_b      <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_command(opcode, cp, a, b);
   endtask

   // Stops offering commands and waits until every owed grid command has arrived.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.ops_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes grid size and insert mode on an idle block, optionally the unused index.
   task automatic set_grid(input logic [CSR_DATA_W-1:0] rows, input logic [CSR_DATA_W-1:0] cols,
                           input bit ins, input bit spare);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  val [4];
      int                     writes;
      idx[0] = CSR_GRID_ROWS;
      val[0] = rows;
      idx[1] = CSR_GRID_COLS;
      val[1] = cols;
      idx[2] = CSR_INSERT_MODE;
      // Upper bits of the insert mode write carry noise; only bit 0 counts.
      val[2] = {(CSR_DATA_W-1)'($urandom_range(255)), ins};
      idx[3] = CSR_SPARE;
      val[3] = CSR_DATA_W'($urandom());
      writes = spare ? 4 : 3;
      drain();
      for (int i = 0; i < writes; i++) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_data     <= val[i];
         @(posedge clock);
         tracker.write_register(idx[i], val[i]);
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [ARG_W-1:0] pick_arg(int unsigned span);
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return ARG_W'($urandom());
         default: return ARG_W'($urandom_range(1, span));
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] pick_code_point();
      int unsigned r;
      int unsigned v;
      r = $urandom_range(9);
      if (r < 4) begin
         v = $urandom_range(32'h20, 32'h7E);
      end else if (r < 6) begin
         case ($urandom_range(5))
            0: v = $urandom_range(32'h1100, 32'h115F);
            1: v = $urandom_range(32'h4E00, 32'h9FFF);
            2: v = $urandom_range(32'hAC00, 32'hD7A3);
            3: v = $urandom_range(32'hFF01, 32'hFF60);
            4: v = $urandom_range(32'h1F300, 32'h1F64F);
            default: v = $urandom_range(32'h20000, 32'h3FFFD);
         endcase
      end else if (r == 6) begin
         case ($urandom_range(3))
            0: v = $urandom_range(32'h0300, 32'h036F);
            1: v = $urandom_range(32'h0591, 32'h05BD);
            2: v = $urandom_range(32'h20D0, 32'h20FF);
            default: v = $urandom_range(32'hFE20, 32'hFE2F);
         endcase
      end else if (r == 7) begin
         v = BOUNDARY_POINTS[$urandom_range(NUM_BOUNDARY - 1)];
      end else begin
         v = $urandom_range(0, 32'h10FFFF);
      end
      return CODE_W'(v);
   endfunction

   // Mostly printing and line movement so that wraps and scrolls happen often;
   // a tenth of the commands have a fully random opcode, unknown ones included.
   task automatic random_commands(input int count);
      int unsigned         r;
      int unsigned         span;
      logic [OPCODE_W-1:0] opcode;
      logic [ARG_W-1:0]    a;
      logic [ARG_W-1:0]    b;
      for (int i = 0; i < count; i++) begin
         span = ((tracker.rows > tracker.cols) ? tracker.rows : tracker.cols) + 2;
         r    = $urandom_range(99);
         a    = pick_arg(span);
         b    = pick_arg(span);
         if (r < 45) opcode = OP_PRINT;
         else if (r < 55) opcode = OP_NEWLINE;
         else if (r < 60) opcode = OP_REV_INDEX;
         else if (r < 90) opcode = OPCODE_W'($urandom_range(OP_NEWLINE, OP_RESET));
         else opcode = OPCODE_W'($urandom());
         send_command(opcode, pick_code_point(), a, b);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rows;
      logic [CSR_DATA_W-1:0] cols;
      bit                    ins;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      req_valid      = 1'b0;
      req_opcode     = '0;
      req_code_point = '0;
      req_arg_a      = '0;
      req_arg_b      = '0;
      tracker        = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed commands on the 24 by 80 grid left by reset.
      send_command(OP_PRINT, 21'h41, '0, '0);
      send_command(OP_PRINT, 21'h4E00, '0, '0);
      send_command(OP_PRINT, 21'h0300, '0, '0);
      send_command(OP_PRINT, 21'h0, '0, '0);
      send_command(OP_PRINT, 21'h10FFFF, '1, '1);
      // A wide character in the last column gets no filler and leaves a wrap pending.
      send_command(OP_LINE_END, '0, '0, '0);
      send_command(OP_PRINT, 21'hAC00, '0, '0);
      send_command(OP_PRINT, 21'h3FFFD, '0, '0);
      send_command(OP_BACKSPACE, '0, '0, '0);
      send_command(OP_LEFT, '0, '0, '0);
      send_command(OP_RIGHT, '0, '1, '0);
      send_command(OP_DOWN, '0, '1, '0);
      send_command(OP_NEWLINE, '0, '0, '0);
      // Region of rows 3 to 5: scroll at both edges, then move below and above it.
      send_command(OP_SET_REGION, '0, 16'd3, 16'd5);
      send_command(OP_REV_INDEX, '0, '0, '0);
      send_command(OP_SET_POS, '0, 16'd5, '0);
      send_command(OP_NEWLINE, '0, '0, '0);
      send_command(OP_SET_ROW, '0, '1, '0);
      send_command(OP_NEWLINE, '0, '0, '0);
      send_command(OP_SET_ROW, '0, 16'd2, '0);
      send_command(OP_REV_INDEX, '0, '0, '0);
      send_command(OP_SAVE, '0, '0, '0);
      // Bottom above top falls back to the last row; a top past the grid to row 1.
      send_command(OP_SET_REGION, '0, 16'd10, 16'd4);
      send_command(OP_RESTORE, '0, '0, '0);
      send_command(OP_SET_REGION, '0, '1, '0);
      send_command(OP_UNUSED_TOP, '1, '1, '1);
      send_command(OP_RESET, '0, '0, '0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         rows = PHASE_ROWS[p];
         cols = PHASE_COLS[p];
         ins  = PHASE_INSERT[p];
         if (p == NUM_PHASES - 1) begin
            rows = CSR_DATA_W'($urandom_range(1, 12));
            cols = CSR_DATA_W'($urandom_range(1, 16));
            ins  = $urandom_range(1);
         end
         set_grid(rows, cols, ins, p == 4);
         quiet = (p == 6);
         random_commands(PHASE_ITEMS);
         quiet = 1'b0;
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.ops_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
